@@ rtl/periodic_task_timer_table_core_macros.svh @@
// assertion helpers used by the timer table engine rtl (pttt_back)
`ifndef PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_CORE_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PTTT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define PTTT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `PTTT_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

@@ rtl/pttt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt_pkg
// Shared codes, widths and types of the periodic task timer table.
// ---------------------------------------------------------------------------
package pttt_pkg;

   localparam int OPC_BITS  = 3;
   localparam int MODE_BITS = 8;
   localparam int REF_BITS  = 16;
   localparam int WORD_BITS = 32;
   localparam int KIND_BITS = 2;
   localparam int CSR_INDEX_BITS = 8;

   localparam logic [OPC_BITS-1:0] OP_TICK    = 3'd0;
   localparam logic [OPC_BITS-1:0] OP_ADD     = 3'd1;
   localparam logic [OPC_BITS-1:0] OP_DELETE  = 3'd2;
   localparam logic [OPC_BITS-1:0] OP_PAUSE   = 3'd3;
   localparam logic [OPC_BITS-1:0] OP_UNPAUSE = 3'd4;
   localparam logic [OPC_BITS-1:0] OP_CLEAR   = 3'd5;

   localparam logic [KIND_BITS-1:0] KIND_FIRED   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_EXPIRED = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REJECT  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_MAX   = 8'd1;

   localparam logic [WORD_BITS-1:0] STOP_LIMIT_RESET = 32'h7FFF_FFFF;
   localparam logic [WORD_BITS-1:0] STOP_MAX_RESET   = 32'hFFFF_FFFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCNT_BITS   = 2;

   typedef struct packed {
      logic is_tick;
      logic is_add;
      logic is_delete;
      logic is_pause;
      logic is_unpause;
      logic is_clear;
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type          cls;
      logic [WORD_BITS-1:0]   now_time;
      logic [MODE_BITS-1:0]   mode_code;
      logic [REF_BITS-1:0]    task_ref;
      logic [WORD_BITS-1:0]   interval_ticks;
      logic [WORD_BITS-1:0]   start_offset;
      logic [WORD_BITS-1:0]   stop_value;
      logic [WORD_BITS-1:0]   payload;
   } cmd_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [REF_BITS-1:0]  task_ref;
      logic [WORD_BITS-1:0] payload;
   } result_type;

endpackage

@@ rtl/pttt_channels.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt channels
// Valid/ready channel interfaces for requests, results and register writes.
// ---------------------------------------------------------------------------
interface pttt_req_if;
   logic                             valid;
   logic                             ready;
   logic [pttt_pkg::OPC_BITS-1:0]    opcode;
   logic [pttt_pkg::WORD_BITS-1:0]   now_time;
   logic [pttt_pkg::MODE_BITS-1:0]   mode_code;
   logic [pttt_pkg::REF_BITS-1:0]    task_ref;
   logic [pttt_pkg::WORD_BITS-1:0]   interval_ticks;
   logic [pttt_pkg::WORD_BITS-1:0]   start_offset;
   logic [pttt_pkg::WORD_BITS-1:0]   stop_value;
   logic [pttt_pkg::WORD_BITS-1:0]   payload;
   modport source (output valid, opcode, now_time, mode_code, task_ref, interval_ticks,
                   start_offset, stop_value, payload, input ready);
   modport sink (input valid, opcode, now_time, mode_code, task_ref, interval_ticks,
                 start_offset, stop_value, payload, output ready);
endinterface

interface pttt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pttt_pkg::KIND_BITS-1:0]   result_kind;
   logic [pttt_pkg::REF_BITS-1:0]    result_ref;
   logic [pttt_pkg::WORD_BITS-1:0]   result_payload;
   logic                             last_of_run;
   modport source (output valid, result_kind, result_ref, result_payload, last_of_run,
                   input ready);
   modport sink (input valid, result_kind, result_ref, result_payload, last_of_run,
                 output ready);
endinterface

interface pttt_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [pttt_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [pttt_pkg::WORD_BITS-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pttt_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module pttt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pttt_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt_front
// Request intake: decodes the opcode and queues valid commands.
// ---------------------------------------------------------------------------
module pttt_front (
   pttt_req_if.sink          req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output pttt_pkg::cmd_type push_cmd
);

   pttt_pkg::cmd_class_type cls;
   logic                    known;

   always_comb begin
      cls = '0;
      case (req_chan.opcode)
         pttt_pkg::OP_TICK:    cls.is_tick    = 1'b1;
         pttt_pkg::OP_ADD:     cls.is_add     = 1'b1;
         pttt_pkg::OP_DELETE:  cls.is_delete  = 1'b1;
         pttt_pkg::OP_PAUSE:   cls.is_pause   = 1'b1;
         pttt_pkg::OP_UNPAUSE: cls.is_unpause = 1'b1;
         pttt_pkg::OP_CLEAR:   cls.is_clear   = 1'b1;
         default:              cls = '0;
      endcase
   end

   assign known = |cls;

   // unknown opcodes are taken and dropped
   assign push_valid     = req_chan.valid && known;
   assign req_chan.ready = push_ready || !known;

   assign push_cmd.cls            = cls;
   assign push_cmd.now_time       = req_chan.now_time;
   assign push_cmd.mode_code      = req_chan.mode_code;
   assign push_cmd.task_ref       = req_chan.task_ref;
   assign push_cmd.interval_ticks = req_chan.interval_ticks;
   assign push_cmd.start_offset   = req_chan.start_offset;
   assign push_cmd.stop_value     = req_chan.stop_value;
   assign push_cmd.payload        = req_chan.payload;

endmodule

@@ rtl/pttt_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt_queue
// Two entry command queue between intake and table engine.
// ---------------------------------------------------------------------------
module pttt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pttt_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pttt_pkg::cmd_type pop_cmd
);

   pttt_pkg::cmd_type                  mem_ff [pttt_pkg::QUEUE_DEPTH];
   logic [pttt_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pttt_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pttt_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                               do_push, do_pop;

   assign push_ready = (count_ff != pttt_pkg::QCNT_BITS'(pttt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/pttt_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt_back
// Table engine: walks the task slots for each command and emits results.
// ---------------------------------------------------------------------------
`include "periodic_task_timer_table_core_macros.svh"

module pttt_back #(
   parameter int NUM_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  pttt_pkg::cmd_type cmd,
   pttt_csr_if.sink          csr_chan,
   pttt_rsp_if.source        rsp_chan
);

   localparam int IDX_BITS = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int W        = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam logic [W-1:0] TIME_MAX = W'(((W+1)'(1)) << TIME_BITS) - W'(1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_STOPC = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   typedef struct packed {
      logic [pttt_pkg::REF_BITS-1:0]  task_ref;
      logic [pttt_pkg::MODE_BITS-1:0] mode_code;
      logic                           paused;
      logic                           started;
      logic [W-1:0]                   start;
      logic [W-1:0]                   stop;
      logic [W-1:0]                   interval;
      logic [W-1:0]                   last;
      logic [pttt_pkg::WORD_BITS-1:0] payload;
   } entry_type;

   localparam int ENT_BITS = $bits(entry_type);

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] sum;
      sum = (W+1)'(a & TIME_MAX) + (W+1)'(b & TIME_MAX);
      sat_add = (sum > (W+1)'(TIME_MAX)) ? TIME_MAX : sum[W-1:0];
   endfunction

   logic [2:0]                     state_ff, state_in;
   logic [IDX_BITS-1:0]            idx_ff, idx_in;
   pttt_pkg::cmd_type              cmd_ff, cmd_in;
   entry_type                      ent_ff, ent_in;
   logic [NUM_TASKS-1:0]           valid_ff, valid_in;
   logic                           fire_ff, fire_in;
   logic                           exp_ff, exp_in;
   logic                           rej_ff, rej_in;
   logic                           hold_valid_ff, hold_valid_in;
   pttt_pkg::result_type           hold_ff, hold_in;
   logic                           out_valid_ff, out_valid_in;
   pttt_pkg::result_type           out_ff, out_in;
   logic                           out_last_ff, out_last_in;
   logic [pttt_pkg::WORD_BITS-1:0] limit_ff, limit_in;
   logic [pttt_pkg::WORD_BITS-1:0] max_ff, max_in;

   logic                 ram_we;
   logic [ENT_BITS-1:0]  ram_wd;
   logic [ENT_BITS-1:0]  ram_rd;
   entry_type            rd_ent, new_ent, upd_ent;
   logic                 out_free, push_ok, push, advance, idx_last;
   pttt_pkg::result_type push_res;
   logic [W-1:0]         now_w;
   logic                 mode_skip, ref_hit, do_fire, do_exp;

   pttt_ram #(
      .WIDTH (ENT_BITS),
      .DEPTH (NUM_TASKS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wd),
      .rd_addr (idx_ff),
      .rd_data (ram_rd)
   );

   assign rd_ent   = entry_type'(ram_rd);
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign push_ok  = !hold_valid_ff || out_free;
   assign idx_last = (idx_ff == IDX_BITS'(NUM_TASKS - 1));
   assign now_w    = W'(cmd_ff.now_time) & TIME_MAX;
   assign mode_skip = (rd_ent.mode_code != '0) && (cmd_ff.mode_code != '0) &&
                      (rd_ent.mode_code != cmd_ff.mode_code);
   assign ref_hit  = valid_ff[idx_ff] && (rd_ent.task_ref == cmd_ff.task_ref);
   assign do_fire  = (W+1)'(now_w) > ((W+1)'(ent_ff.last) + (W+1)'(ent_ff.interval));
   assign do_exp   = (now_w > ent_ff.stop) || (ent_ff.start == ent_ff.stop);

   always_comb begin
      new_ent.task_ref  = cmd_ff.task_ref;
      new_ent.mode_code = cmd_ff.mode_code;
      new_ent.paused    = 1'b0;
      new_ent.started   = 1'b0;
      new_ent.start     = W'(cmd_ff.start_offset);
      new_ent.stop      = W'(cmd_ff.stop_value);
      new_ent.interval  = W'(cmd_ff.interval_ticks);
      new_ent.last      = '0;
      new_ent.payload   = cmd_ff.payload;
      upd_ent = ent_ff;
      if (do_fire) begin
         upd_ent.last = now_w;
      end
   end

   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      ent_in        = ent_ff;
      valid_in      = valid_ff;
      fire_in       = fire_ff;
      exp_in        = exp_ff;
      rej_in        = rej_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      limit_in      = limit_ff;
      max_in        = max_ff;
      ram_we        = 1'b0;
      ram_wd        = ram_rd;
      cmd_ready     = 1'b0;
      push          = 1'b0;
      push_res      = '0;
      advance       = 1'b0;

      if (out_free) begin
         out_valid_in = 1'b0;
      end

      if (csr_chan.valid) begin
         if (csr_chan.index == pttt_pkg::REG_STOP_LIMIT) begin
            limit_in = csr_chan.data;
         end else if (csr_chan.index == pttt_pkg::REG_STOP_MAX) begin
            max_in = csr_chan.data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               idx_in = '0;
               if (cmd.cls.is_clear) begin
                  valid_in = '0;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (cmd_ff.cls.is_tick) begin
               if (!valid_ff[idx_ff] || rd_ent.paused || mode_skip) begin
                  advance = 1'b1;
               end else begin
                  ent_in = rd_ent;
                  if (rd_ent.started) begin
                     state_in = S_CHECK;
                  end else begin
                     ent_in.started = 1'b1;
                     ent_in.start   = sat_add(rd_ent.start, now_w);
                     ent_in.last    = sat_add(rd_ent.start, now_w);
                     state_in       = S_STOPC;
                  end
               end
            end else if (cmd_ff.cls.is_add) begin
               if (!valid_ff[idx_ff]) begin
                  ram_we           = 1'b1;
                  ram_wd           = ENT_BITS'(new_ent);
                  valid_in[idx_ff] = 1'b1;
                  state_in         = S_FLUSH;
               end else if (idx_last) begin
                  rej_in   = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  advance = 1'b1;
               end
            end else begin
               if (ref_hit) begin
                  if (cmd_ff.cls.is_delete) begin
                     valid_in[idx_ff] = 1'b0;
                  end else begin
                     ram_we = 1'b1;
                     ram_wd = ENT_BITS'({rd_ent.task_ref, rd_ent.mode_code,
                                         cmd_ff.cls.is_pause, rd_ent.started, rd_ent.start,
                                         rd_ent.stop, rd_ent.interval, rd_ent.last,
                                         rd_ent.payload});
                  end
                  state_in = S_FLUSH;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         S_STOPC: begin
            if (ent_ff.stop >= W'(limit_ff)) begin
               ent_in.stop = W'(max_ff);
            end else begin
               ent_in.stop = sat_add(ent_ff.start, ent_ff.stop);
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            ram_we  = 1'b1;
            ram_wd  = ENT_BITS'(upd_ent);
            ent_in  = upd_ent;
            fire_in = do_fire;
            exp_in  = do_exp;
            if (do_exp) begin
               valid_in[idx_ff] = 1'b0;
            end
            if (do_fire || do_exp) begin
               state_in = S_EMIT;
            end else begin
               advance = 1'b1;
            end
         end
         S_EMIT: begin
            if (rej_ff) begin
               if (push_ok) begin
                  push     = 1'b1;
                  push_res = '{pttt_pkg::KIND_REJECT, cmd_ff.task_ref, '0};
                  rej_in   = 1'b0;
               end
            end else if (fire_ff) begin
               if (push_ok) begin
                  push     = 1'b1;
                  push_res = '{pttt_pkg::KIND_FIRED, ent_ff.task_ref, ent_ff.payload};
                  fire_in  = 1'b0;
               end
            end else if (exp_ff) begin
               if (push_ok) begin
                  push     = 1'b1;
                  push_res = '{pttt_pkg::KIND_EXPIRED, ent_ff.task_ref, '0};
                  exp_in   = 1'b0;
               end
            end else begin
               advance = 1'b1;
            end
         end
         S_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = hold_ff;
               out_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (idx_last) begin
            state_in = S_FLUSH;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = S_READ;
         end
      end

      // a newer beat pushes the held one out, so only the final one carries last
      if (push) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = hold_ff;
            out_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_in       = push_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         valid_ff      <= '0;
         fire_ff       <= 1'b0;
         exp_ff        <= 1'b0;
         rej_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         limit_ff      <= pttt_pkg::STOP_LIMIT_RESET;
         max_ff        <= pttt_pkg::STOP_MAX_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         fire_ff       <= fire_in;
         exp_ff        <= exp_in;
         rej_ff        <= rej_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         limit_ff      <= limit_in;
         max_ff        <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ent_ff      <= ent_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result_kind    = out_ff.kind;
   assign rsp_chan.result_ref     = out_ff.task_ref;
   assign rsp_chan.result_payload = out_ff.payload;
   assign rsp_chan.last_of_run    = out_last_ff;

   `PTTT_ASSERT(a_idle_hold_empty, clock, reset, (state_ff == S_IDLE) |-> !hold_valid_ff, "held beat left in idle")
   `PTTT_ASSERT(a_write_states, clock, reset, ram_we |-> (state_ff == S_EVAL || state_ff == S_CHECK), "slot write outside eval or check")
   `PTTT_ASSERT(a_stopc_to_check, clock, reset, (state_ff == S_STOPC) |=> (state_ff == S_CHECK), "stop conversion not followed by check")
   `PTTT_ASSERT_NEVER(a_no_reject_on_tick, clock, reset, rej_ff && cmd_ff.cls.is_tick, "reject pending during tick")

endmodule

@@ rtl/periodic_task_timer_table_core.sv @@
`timescale 1ns / 1ps
// a command walks the slots one at a time; a skipped or passed slot takes S_READ and S_EVAL
// an active slot on a tick adds S_STOPC on its first tick, S_CHECK, and S_EMIT for results
// a new command is taken only in S_IDLE; add, delete, pause and unpause stop the walk early
// clear empties all slots; results leave one beat after the next is known or the walk ends
// reset is synchronous: slot valid bits, queue and handshake state clear at once, no sweep
// ---------------------------------------------------------------------------
// periodic_task_timer_table_core
// Periodic task timer table: intake, command queue and slot walking engine.
// ---------------------------------------------------------------------------
module periodic_task_timer_table_core #(
   parameter int NUM_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   pttt_req_if.sink    req_chan,
   pttt_rsp_if.source  rsp_chan,
   pttt_csr_if.sink    csr_chan
);

   logic              push_valid, push_ready;
   pttt_pkg::cmd_type push_cmd;
   logic              pop_valid, pop_ready;
   pttt_pkg::cmd_type pop_cmd;

   pttt_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   pttt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pttt_back #(
      .NUM_TASKS (NUM_TASKS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .csr_chan  (csr_chan),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ tb/sv/pttt_tb_channels.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt testbench channel note
// The block's channel interfaces live with the rtl; this file keeps the
// testbench's own shared result record used by the checker.
// ---------------------------------------------------------------------------
package pttt_tb_pkg;
   import pttt_pkg::*;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [REF_BITS-1:0]  tref;
      logic [WORD_BITS-1:0] pay;
      logic                 last;
   } beat_type;
endpackage

@@ tb/sv/pttt_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pttt checker
// Watches request, result and register channels, keeps its own copy of the
// task table, predicts the result beats of each request and compares them.
// ---------------------------------------------------------------------------
module pttt_checker
   import pttt_pkg::*;
   import pttt_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pttt_req_if        req_chan,
   pttt_rsp_if        rsp_chan,
   pttt_csr_if        csr_chan,
   output int         fail_count,
   output int         pending,
   output int         fired_seen,
   output int         expired_seen,
   output int         reject_seen
);
   localparam int SLOTS = 16;

   logic [WORD_BITS-1:0] lim_q, max_q;
   logic                 t_valid  [SLOTS];
   logic [REF_BITS-1:0]  t_ref    [SLOTS];
   logic [MODE_BITS-1:0] t_mode   [SLOTS];
   logic                 t_paused [SLOTS];
   logic                 t_started[SLOTS];
   logic [WORD_BITS-1:0] t_start  [SLOTS];
   logic [WORD_BITS-1:0] t_stop   [SLOTS];
   logic [WORD_BITS-1:0] t_intv   [SLOTS];
   logic [WORD_BITS-1:0] t_last   [SLOTS];
   logic [WORD_BITS-1:0] t_pay    [SLOTS];
   beat_type             beats_due[$];

   function automatic logic [WORD_BITS-1:0] sat_sum(logic [WORD_BITS-1:0] a,
                                                    logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_BITS] ? '1 : s[WORD_BITS-1:0];
   endfunction

   task automatic push_beat(logic [KIND_BITS-1:0] k, logic [REF_BITS-1:0] r,
                            logic [WORD_BITS-1:0] p);
      beat_type b;
      b.kind = k; b.tref = r; b.pay = p; b.last = 1'b0;
      beats_due.insert(beats_due.size(), b);
   endtask

   task automatic predict_request();
      int n0, hit, free_slot;
      logic [WORD_BITS-1:0] st;
      n0 = beats_due.size();
      case (req_chan.opcode)
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!t_valid[i] || t_paused[i]) continue;
               if (t_mode[i] != 0 && req_chan.mode_code != 0 && t_mode[i] != req_chan.mode_code)
                  continue;
               if (!t_started[i]) begin
                  st = sat_sum(t_start[i], req_chan.now_time);
                  t_started[i] = 1'b1;
                  t_start[i] = st;
                  t_last[i] = st;
                  t_stop[i] = (t_stop[i] >= lim_q) ? max_q : sat_sum(st, t_stop[i]);
               end
               if ({1'b0, req_chan.now_time} > {1'b0, t_last[i]} + {1'b0, t_intv[i]}) begin
                  t_last[i] = req_chan.now_time;
                  push_beat(KIND_FIRED, t_ref[i], t_pay[i]);
               end
               if (req_chan.now_time > t_stop[i] || t_start[i] == t_stop[i]) begin
                  t_valid[i] = 1'b0;
                  push_beat(KIND_EXPIRED, t_ref[i], '0);
               end
            end
         end
         OP_ADD: begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--) if (!t_valid[i]) free_slot = i;
            if (free_slot < 0) begin
               push_beat(KIND_REJECT, req_chan.task_ref, '0);
            end else begin
               t_valid[free_slot]   = 1'b1;
               t_ref[free_slot]     = req_chan.task_ref;
               t_mode[free_slot]    = req_chan.mode_code;
               t_paused[free_slot]  = 1'b0;
               t_started[free_slot] = 1'b0;
               t_intv[free_slot]    = req_chan.interval_ticks;
               t_start[free_slot]   = req_chan.start_offset;
               t_stop[free_slot]    = req_chan.stop_value;
               t_last[free_slot]    = '0;
               t_pay[free_slot]     = req_chan.payload;
            end
         end
         OP_DELETE, OP_PAUSE, OP_UNPAUSE: begin
            hit = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (t_valid[i] && t_ref[i] == req_chan.task_ref) hit = i;
            if (hit >= 0) begin
               if (req_chan.opcode == OP_DELETE) t_valid[hit] = 1'b0;
               else t_paused[hit] = (req_chan.opcode == OP_PAUSE);
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) t_valid[i] = 1'b0;
         end
         default: ;
      endcase
      if (beats_due.size() > n0) beats_due[beats_due.size() - 1].last = 1'b1;
   endtask

   task automatic compare_beat();
      beat_type e;
      if (beats_due.size() == 0) begin
         $error("result beat with nothing expected: kind %0d ref %0h",
                rsp_chan.result_kind, rsp_chan.result_ref);
         fail_count++;
         return;
      end
      e = beats_due.pop_front();
      if (rsp_chan.result_kind !== e.kind) begin
         $error("result_kind expected %0d actual %0d", e.kind, rsp_chan.result_kind);
         fail_count++;
      end
      if (rsp_chan.result_ref !== e.tref) begin
         $error("result_ref expected %0h actual %0h", e.tref, rsp_chan.result_ref);
         fail_count++;
      end
      if (rsp_chan.result_payload !== e.pay) begin
         $error("result_payload expected %0h actual %0h", e.pay, rsp_chan.result_payload);
         fail_count++;
      end
      if (rsp_chan.last_of_run !== e.last) begin
         $error("last_of_run expected %0b actual %0b", e.last, rsp_chan.last_of_run);
         fail_count++;
      end
      case (e.kind)
         KIND_FIRED:   fired_seen++;
         KIND_EXPIRED: expired_seen++;
         default:      reject_seen++;
      endcase
   endtask

   initial begin
      fail_count = 0; fired_seen = 0; expired_seen = 0; reject_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         lim_q <= STOP_LIMIT_RESET;
         max_q <= STOP_MAX_RESET;
         for (int i = 0; i < SLOTS; i++) t_valid[i] = 1'b0;
         beats_due.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == REG_STOP_LIMIT) lim_q <= csr_chan.data;
            else if (csr_chan.index == REG_STOP_MAX) max_q <= csr_chan.data;
         end
         if (rsp_chan.valid && rsp_chan.ready) compare_beat();
         if (req_chan.valid && req_chan.ready) predict_request();
      end
      pending = beats_due.size();
   end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives requests, register writes and result back-pressure into the timer
// table, with bursty sending, random stalls and one long hold-off.
// ---------------------------------------------------------------------------
module tb;
   import pttt_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock, reset;
   int   fail_count, pending, fired_seen, expired_seen, reject_seen;
   int   idle_cycles, sent;
   bit   hold_off, timed_out;

   pttt_req_if req_chan ();
   pttt_rsp_if rsp_chan ();
   pttt_csr_if csr_chan ();

   periodic_task_timer_table_core uut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   pttt_checker chk (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan),
      .fail_count(fail_count), .pending(pending), .fired_seen(fired_seen),
      .expired_seen(expired_seen), .reject_seen(reject_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_chan.ready <= 1'b0;
         else if ($urandom_range(0, 3) == 0) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         else rsp_chan.ready <= 1'b1;
      end
   end

   // no beat accepted for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1'b1;
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send(logic [2:0] op, logic [31:0] now, logic [7:0] mode, logic [15:0] r,
                       logic [31:0] iv, logic [31:0] so, logic [31:0] sv, logic [31:0] pl);
      req_chan.valid          <= 1'b1;
      req_chan.opcode         <= op;
      req_chan.now_time       <= now;
      req_chan.mode_code      <= mode;
      req_chan.task_ref       <= r;
      req_chan.interval_ticks <= iv;
      req_chan.start_offset   <= so;
      req_chan.stop_value     <= sv;
      req_chan.payload        <= pl;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic gap();
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // queued commands that give no beats may still be walking the table
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic rand_item(logic [31:0] now);
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_TICK;
      else if (pick < 70) op = OP_ADD;
      else if (pick < 78) op = OP_DELETE;
      else if (pick < 86) op = OP_PAUSE;
      else if (pick < 94) op = OP_UNPAUSE;
      else if (pick < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(6, 7));
      send(op, now, ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
           16'($urandom_range(0, 7)) | (($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'h0),
           ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40),
           ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 30),
           ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 120),
           $urandom);
   endtask

   task automatic random_phase(int count);
      logic [31:0] now;
      int burst;
      now = $urandom_range(0, 1000);
      while (count > 0) begin
         burst = ($urandom_range(0, 4) == 0) ? 20 : $urandom_range(1, 6);
         for (int k = 0; k < burst && count > 0; k++) begin
            now = now + $urandom_range(0, 25);
            if ($urandom_range(0, 30) == 0) now = $urandom;
            rand_item(now);
            count--;
         end
         gap();
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      hold_off = 1'b0; timed_out = 1'b0; sent = 0;
      req_chan.valid = 1'b0; req_chan.opcode = OP_TICK; req_chan.now_time = '0;
      req_chan.mode_code = '0; req_chan.task_ref = '0; req_chan.interval_ticks = '0;
      req_chan.start_offset = '0; req_chan.stop_value = '0; req_chan.payload = '0;
      csr_chan.valid = 1'b0; csr_chan.index = REG_STOP_LIMIT; csr_chan.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every opcode, saturation, duplicates, full table
      send(OP_ADD, 0, 0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      send(OP_ADD, 0, 8'hFF, 16'h0001, 0, 0, 0, 32'hA5A5_5A5A);
      send(OP_ADD, 0, 8'h02, 16'h0002, 5, 10, 32'hFFFF_FFFF, 32'h1234_5678);
      send(OP_ADD, 0, 8'h02, 16'h0002, 3, 0, 40, 32'h0BAD_F00D);
      send(OP_PAUSE, 0, 0, 16'h0002, 0, 0, 0, 0);
      send(OP_TICK, 32'hFFFF_FFF0, 8'h02, 0, 0, 0, 0, 0);
      send(OP_TICK, 32'd100, 8'hFF, 0, 0, 0, 0, 0);
      send(OP_UNPAUSE, 0, 0, 16'h0002, 0, 0, 0, 0);
      send(OP_TICK, 32'd200, 8'h00, 0, 0, 0, 0, 0);
      send(OP_DELETE, 0, 0, 16'h0002, 0, 0, 0, 0);
      send(OP_DELETE, 0, 0, 16'h7777, 0, 0, 0, 0);
      send(3'd6, 0, 0, 0, 0, 0, 0, 0);
      send(3'd7, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int k = 0; k < 17; k++)
         send(OP_ADD, 0, 8'($urandom), 16'(k + 16'h100), $urandom_range(0, 5),
              $urandom_range(0, 5), $urandom_range(0, 20), $urandom);
      send(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
      send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      drain();

      // long receiver hold-off while the sender keeps offering
      for (int k = 0; k < 12; k++)
         send(OP_ADD, 0, 0, 16'(k), 0, 0, 5, 32'(k));
      hold_off = 1'b1;
      fork
         begin
            for (int k = 0; k < 8; k++) send(OP_TICK, 32'(k * 3 + 1), 0, 0, 0, 0, 0, 0);
            req_chan.valid <= 1'b0;
         end
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      drain();

      random_phase(40);
      csr_write(REG_STOP_LIMIT, 32'd0);
      csr_write(REG_STOP_MAX, 32'd0);
      random_phase(30);
      csr_write(REG_STOP_LIMIT, 32'hFFFF_FFFF);
      csr_write(REG_STOP_MAX, 32'hFFFF_FFFF);
      random_phase(30);
      csr_write(REG_STOP_LIMIT, 32'd60);
      csr_write(REG_STOP_MAX, 32'd5000);
      random_phase(30);

      $display("sent %0d requests over four register settings", sent);
      $display("checked %0d fired, %0d expired and %0d rejected beats",
               fired_seen, expired_seen, reject_seen);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pttt_pkg.sv
rtl/pttt_channels.sv
rtl/pttt_ram.sv
rtl/pttt_front.sv
rtl/pttt_queue.sv
rtl/pttt_back.sv
rtl/periodic_task_timer_table_core.sv
tb/sv/pttt_tb_channels.sv
tb/sv/pttt_checker.sv
tb/sv/tb.sv
